// ----- hdl/dsfn_pkg.sv -----
package dsfn_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FEED_RD,
		ST_FEED_WR,
		ST_AVG,
		ST_PEAK,
		ST_RD_MEM,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FEED,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		PASS_DIAMOND,
		PASS_SQ_A,
		PASS_SQ_B
	} pass_t;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_FEED  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic CFG_SIZE_LOG2 = 1'b0;
	localparam logic CFG_GRID_LOG2 = 1'b1;

	localparam logic [3:0]  SIZE_LOG2_RESET = 4'd8;
	localparam logic [3:0]  GRID_LOG2_RESET = 4'd4;
	localparam logic [14:0] AMP_START       = 15'h7FFF;

	// Bit positions inside the result tuser.
	localparam int USER_DONE  = 0;
	localparam int USER_ERROR = 1;

	typedef struct packed {
		logic [7:0] noise_value;
		logic       last;
		logic       error;
	} res_t;

endpackage

// ----- hdl/diamond_square_fractal_noise.sv -----
// Channel   Direction  Beat contents
// s_*       in         tdata[14:0] random_value; tuser[1:0] mode
// m_*       out        tdata[7:0] noise_value; tuser[0] done_res, [1] error; tlast last
// cfg_*     in         cfg_index selects the register, cfg_data[3:0] its value
//
// A start beat runs a clearing pass over all 4**side_log2 cells of the height memory.
// A random word is added into its grid point by a read and a write; the last word of
// each coarser level runs the diamond and square passes over the one height memory.
// The last word of the finest level instead runs a peak scan over all 4**side_log2 cells.
// A read beat fetches one cell and scales it with the bit-serial normalizing divider.
// Reset clears control state only; a start beat must precede any map use.
// Input is taken only between items; a stalled result holds the sequencer.
module diamond_square_fractal_noise #(
	parameter int MAX_SIZE_LOG2 = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [14:0] random_value
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] noise_value
	output logic [1:0]  m_tuser,   // [0] done_res, [1] error
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import dsfn_pkg::*;

	localparam int AW    = 2 * MAX_SIZE_LOG2;
	localparam int CW    = MAX_SIZE_LOG2;
	localparam int L2W   = $clog2(MAX_SIZE_LOG2 + 1);
	localparam int DEPTH = 1 << AW;

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_data;
	logic        mem_re, mem_we;
	logic [AW-1:0] mem_ra, mem_wa;
	logic [15:0] mem_wd;

	state_t state_q, state_d;
	phase_t phase_q;
	pass_t  pass_q;
	logic [3:0]    reg_size_q, reg_grid_q;
	logic [L2W-1:0] sl_q, lvl_q;
	logic [14:0]   amp_q, rnd_q;
	logic [AW:0]   pos_q, cnt_q;
	logic [AW-1:0] rdidx_q;
	logic [15:0]   peak_q;
	logic          peak_v_s1;
	logic [CW-1:0] gx_q, gy_q;
	logic [2:0]    j_q;
	logic [17:0]   acc_q;
	logic [16:0]   rem_q;
	logic [6:0]    quo_q;
	res_t          res_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_data <= mem[mem_ra];
	end

	// Geometry of the current map and level.
	logic [L2W-1:0] k;
	logic [CW-1:0]  side_mask, g2c, gc, gmax, xb, yb;
	logic [CW:0]    gtot, g2w;
	logic [AW:0]    total, grid_pts;
	logic           last_point;

	// The spacing can equal the full side, so it is formed one bit wider before
	// halving; the full spacing itself wraps to zero, which the side mask allows.
	assign k         = sl_q - lvl_q;
	assign side_mask = CW'(((CW + 1)'(1) << sl_q) - (CW + 1)'(1));
	assign g2w       = (CW + 1)'(1) << lvl_q;
	assign g2c       = CW'(g2w);
	assign gc        = CW'(g2w >> 1);
	assign gtot      = (CW + 1)'(1) << k;
	assign gmax      = CW'(gtot - (CW + 1)'(1));
	assign total     = (AW + 1)'(1) << {sl_q, 1'b0};
	assign grid_pts  = (AW + 1)'(1) << {k, 1'b0};
	assign xb        = gx_q << lvl_q;
	assign yb        = gy_q << lvl_q;
	assign last_point = (gx_q == gmax) && (gy_q == gmax);

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
		input logic [CW-1:0] y, input logic [CW-1:0] m, input logic [L2W-1:0] s);
		cell_addr = (AW'(y & m) << s) | AW'(x & m);
	endfunction

	// Neighbor and target coordinates of the average in progress.
	logic [CW-1:0] nx, ny, tx, ty;
	always_comb begin
		nx = xb;
		ny = yb;
		tx = xb + gc;
		ty = yb + gc;
		case (pass_q)
			PASS_DIAMOND: begin
				case (j_q[1:0])
					2'd0: begin nx = xb;       ny = yb;       end
					2'd1: begin nx = xb + g2c; ny = yb;       end
					2'd2: begin nx = xb;       ny = yb + g2c; end
					default: begin nx = xb + g2c; ny = yb + g2c; end
				endcase
			end
			PASS_SQ_A: begin
				tx = xb + gc;
				ty = yb;
				case (j_q[1:0])
					2'd0: begin nx = xb;       ny = yb;      end
					2'd1: begin nx = xb + g2c; ny = yb;      end
					2'd2: begin nx = xb + gc;  ny = yb - gc; end
					default: begin nx = xb + gc; ny = yb + gc; end
				endcase
			end
			default: begin
				tx = xb;
				ty = yb + gc;
				case (j_q[1:0])
					2'd0: begin nx = xb;      ny = yb;       end
					2'd1: begin nx = xb;      ny = yb + g2c; end
					2'd2: begin nx = xb - gc; ny = yb + gc;  end
					default: begin nx = xb + gc; ny = yb + gc; end
				endcase
			end
		endcase
	end

	// Grid point of the next random word.
	logic [CW-1:0] frow, fcol;
	logic [AW-1:0] feed_addr;
	assign frow      = CW'(pos_q >> k);
	assign fcol      = CW'(pos_q) & gmax;
	assign feed_addr = cell_addr(fcol << lvl_q, frow << lvl_q, side_mask, sl_q);

	// Divider step: remainder stays below the divisor peak + 1.
	logic [16:0] divisor, rem_src;
	logic [17:0] rem_sh;
	logic        q_bit;
	logic [16:0] rem_next;
	assign divisor  = {1'b0, peak_q} + 17'd1;
	assign rem_src  = (j_q == 3'd0) ? {1'b0, rd_data} : rem_q;
	assign rem_sh   = {rem_src, 1'b0};
	assign q_bit    = rem_sh >= {1'b0, divisor};
	assign rem_next = q_bit ? 17'(rem_sh - {1'b0, divisor}) : rem_sh[16:0];

	logic accept;
	logic [17:0] acc_sum;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign acc_sum   = acc_q + 18'(rd_data);

	always_comb begin
		state_d = state_q;
		mem_re  = 1'b0;
		mem_ra  = '0;
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_tuser)
						MODE_START: state_d = ST_CLEAR;
						MODE_FEED:  state_d = (phase_q == PH_FEED) ? ST_FEED_RD : ST_EMIT;
						MODE_READ:  state_d = (phase_q == PH_DONE) ? ST_RD_MEM : ST_EMIT;
						default:    state_d = ST_EMIT;
					endcase
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = cnt_q[AW-1:0];
				if (cnt_q == total - (AW + 1)'(1)) state_d = ST_EMIT;
			end
			ST_FEED_RD: begin
				mem_re  = 1'b1;
				mem_ra  = feed_addr;
				state_d = ST_FEED_WR;
			end
			ST_FEED_WR: begin
				mem_we = 1'b1;
				mem_wa = feed_addr;
				mem_wd = rd_data + 16'(rnd_q & amp_q);
				if (pos_q + (AW + 1)'(1) == grid_pts)
					state_d = (lvl_q != '0) ? ST_AVG : ST_PEAK;
				else
					state_d = ST_EMIT;
			end
			ST_AVG: begin
				if (j_q != 3'd4) begin
					mem_re = 1'b1;
					mem_ra = cell_addr(nx, ny, side_mask, sl_q);
				end else begin
					mem_we = 1'b1;
					mem_wa = cell_addr(tx, ty, side_mask, sl_q);
					mem_wd = acc_sum[17:2];
					if (pass_q == PASS_SQ_B && last_point) state_d = ST_EMIT;
				end
			end
			ST_PEAK: begin
				if (cnt_q != total) begin
					mem_re = 1'b1;
					mem_ra = cnt_q[AW-1:0];
				end else if (!peak_v_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_RD_MEM: begin
				mem_re  = 1'b1;
				mem_ra  = rdidx_q;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (j_q == 3'd7) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!m_tvalid || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	logic [3:0] sl_clamp, gl_clamp;
	assign sl_clamp = (reg_size_q < 4'd1) ? 4'd1 :
		(reg_size_q > 4'(MAX_SIZE_LOG2)) ? 4'(MAX_SIZE_LOG2) : reg_size_q;
	assign gl_clamp = (reg_grid_q > sl_clamp) ? sl_clamp : reg_grid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_size_q <= SIZE_LOG2_RESET;
			reg_grid_q <= GRID_LOG2_RESET;
			phase_q    <= PH_IDLE;
			pass_q     <= PASS_DIAMOND;
			sl_q       <= '0;
			lvl_q      <= '0;
			amp_q      <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
			rdidx_q    <= '0;
			peak_q     <= '0;
			peak_v_s1  <= 1'b0;
			gx_q       <= '0;
			gy_q       <= '0;
			j_q        <= '0;
			acc_q      <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SIZE_LOG2) reg_size_q <= cfg_data;
				if (cfg_index == CFG_GRID_LOG2) reg_grid_q <= cfg_data;
			end
			if (state_q == ST_EMIT && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == MODE_START) begin
						sl_q    <= L2W'(sl_clamp);
						lvl_q   <= L2W'(gl_clamp);
						amp_q   <= AMP_START;
						pos_q   <= '0;
						cnt_q   <= '0;
						peak_q  <= '0;
						rdidx_q <= '0;
						phase_q <= PH_FEED;
					end
					j_q <= '0;
				end
				ST_CLEAR: cnt_q <= cnt_q + (AW + 1)'(1);
				ST_FEED_WR: begin
					if (pos_q + (AW + 1)'(1) == grid_pts) begin
						pos_q     <= '0;
						pass_q    <= PASS_DIAMOND;
						gx_q      <= '0;
						gy_q      <= '0;
						j_q       <= '0;
						cnt_q     <= '0;
						peak_q    <= '0;
						peak_v_s1 <= 1'b0;
					end else begin
						pos_q <= pos_q + (AW + 1)'(1);
					end
				end
				ST_AVG: begin
					if (j_q != 3'd4) begin
						j_q <= j_q + 3'd1;
						acc_q <= (j_q == 3'd0) ? 18'd0 : acc_sum;
					end else begin
						j_q <= '0;
						case (pass_q)
							PASS_DIAMOND: begin
								if (last_point) begin
									pass_q <= PASS_SQ_A;
									gx_q   <= '0;
									gy_q   <= '0;
								end else if (gx_q == gmax) begin
									gx_q <= '0;
									gy_q <= gy_q + CW'(1);
								end else begin
									gx_q <= gx_q + CW'(1);
								end
							end
							PASS_SQ_A: pass_q <= PASS_SQ_B;
							default: begin
								pass_q <= PASS_SQ_A;
								if (last_point) begin
									lvl_q <= lvl_q - L2W'(1);
									amp_q <= amp_q >> 1;
								end else if (gx_q == gmax) begin
									gx_q <= '0;
									gy_q <= gy_q + CW'(1);
								end else begin
									gx_q <= gx_q + CW'(1);
								end
							end
						endcase
					end
				end
				ST_PEAK: begin
					peak_v_s1 <= (cnt_q != total);
					if (cnt_q != total) cnt_q <= cnt_q + (AW + 1)'(1);
					if (peak_v_s1 && rd_data > peak_q) peak_q <= rd_data;
					if (cnt_q == total && !peak_v_s1) begin
						phase_q <= PH_DONE;
						rdidx_q <= '0;
					end
				end
				ST_RD_MEM: j_q <= '0;
				ST_DIV: begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'd7)
						rdidx_q <= AW'((rdidx_q + (AW + 1)'(1)) & (total - (AW + 1)'(1)));
				end
				default: ;
			endcase
		end
	end

	// Result fields and divider datapath need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rnd_q <= s_tdata[14:0];
				res_q <= '{noise_value: 8'd0, last: 1'b0,
					error: !(s_tuser == MODE_START ||
						(s_tuser == MODE_FEED && phase_q == PH_FEED) ||
						(s_tuser == MODE_READ && phase_q == PH_DONE))};
			end
			ST_DIV: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[5:0], q_bit};
				if (j_q == 3'd7) begin
					res_q.noise_value <= {quo_q, q_bit};
					res_q.last <= ((AW + 1)'(rdidx_q) == total - (AW + 1)'(1));
				end
			end
			ST_EMIT: begin
				if (!m_tvalid || m_tready) begin
					m_tdata              <= res_q.noise_value;
					m_tlast              <= res_q.last;
					m_tuser[USER_ERROR]  <= res_q.error;
					m_tuser[USER_DONE]   <= (phase_q == PH_DONE);
				end
			end
			default: ;
		endcase
	end

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mem_we)
		else $error("height memory written between items");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_ERROR] |-> m_tdata == 8'd0 && !m_tlast)
		else $error("rejected item carries data");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[USER_DONE])
		else $error("final byte reported before map done");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_src < divisor)
		else $error("divider remainder out of range");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
	import dsfn_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [7:0] noise;
		logic       done;
		logic       last;
		logic       err;
	} noise_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [3:0]  cfg_data;

	diamond_square_fractal_noise dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted state of the noise map.
	logic [15:0] heights [0:65535];
	int unsigned spacing, feed_pos, peak, read_pos, side_l2, level_l2, amp;
	phase_t      map_phase;
	logic [3:0]  size_reg, grid_reg;

	noise_res_t  expected_bytes[$];
	int          fails;
	int          cycles;
	int          beats_sent, bytes_checked, maps_done;
	bit          gaps_on;
	int          hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned cell_at(int x, int y);
		int m;
		m = (1 << side_l2) - 1;
		return (((y & m) << side_l2) | (x & m)) & 16'hFFFF;
	endfunction

	function automatic logic [15:0] mean4(int unsigned a, int unsigned b, int unsigned c,
			int unsigned d);
		int unsigned s;
		s = heights[a] + heights[b] + heights[c] + heights[d];
		return s[17:2];
	endfunction

	function automatic void close_level();
		int n, g2, g;
		n = 1 << side_l2;
		g2 = spacing;
		g = g2 >> 1;
		if (g != 0) begin
			for (int y = 0; y < n; y += g2)
				for (int x = 0; x < n; x += g2)
					heights[cell_at(x + g, y + g)] = mean4(cell_at(x, y), cell_at(x + g2, y),
						cell_at(x, y + g2), cell_at(x + g2, y + g2));
			for (int y = 0; y < n; y += g2)
				for (int x = 0; x < n; x += g2) begin
					heights[cell_at(x + g, y)] = mean4(cell_at(x, y), cell_at(x + g2, y),
						cell_at(x + g, y - g), cell_at(x + g, y + g));
					heights[cell_at(x, y + g)] = mean4(cell_at(x, y), cell_at(x, y + g2),
						cell_at(x - g, y + g), cell_at(x + g, y + g));
				end
		end
		if (level_l2 == 0) begin
			peak = 0;
			for (int i = 0; i < n * n; i++)
				if (heights[i] > peak)
					peak = heights[i];
			spacing = 0;
			read_pos = 0;
			feed_pos = 0;
			map_phase = PH_DONE;
			maps_done++;
		end else begin
			level_l2--;
			spacing >>= 1;
			amp >>= 1;
			feed_pos = 0;
		end
	endfunction

	function automatic noise_res_t predict_byte(logic [1:0] mode, logic [14:0] word);
		noise_res_t r;
		int unsigned k, cidx, total, i;
		r = '{default: 1'b0};
		case (mode)
			MODE_START: begin
				side_l2 = (size_reg < 1) ? 1 : (size_reg > 8) ? 8 : size_reg;
				level_l2 = (grid_reg > side_l2) ? side_l2 : grid_reg;
				for (int j = 0; j < 65536; j++)
					heights[j] = '0;
				spacing = 1 << level_l2;
				feed_pos = 0;
				peak = 0;
				read_pos = 0;
				amp = 16'h7FFF;
				map_phase = PH_FEED;
			end
			MODE_FEED: begin
				if (map_phase != PH_FEED) begin
					r.err = 1'b1;
				end else begin
					k = side_l2 - level_l2;
					cidx = cell_at((feed_pos & ((1 << k) - 1)) << level_l2,
						(feed_pos >> k) << level_l2);
					heights[cidx] = 16'(heights[cidx] + (word & amp));
					feed_pos++;
					if (feed_pos >= (1 << (2 * k)))
						close_level();
				end
			end
			MODE_READ: begin
				if (map_phase != PH_DONE) begin
					r.err = 1'b1;
				end else begin
					total = 1 << (2 * side_l2);
					i = read_pos & (total - 1);
					r.noise = 8'((heights[i] * 256) / (peak + 1));
					r.last = (i == total - 1);
					read_pos = (i + 1) & (total - 1);
				end
			end
			default: r.err = 1'b1;
		endcase
		r.done = (map_phase == PH_DONE);
		return r;
	endfunction

	// Sender: inputs change on the falling edge, acceptance is seen at the rising edge.
	task automatic send_beat(logic [1:0] mode, logic [14:0] word);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {1'b0, word};
		do @(posedge clk); while (!s_tready);
		expected_bytes.push_back(predict_byte(mode, word));
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SIZE_LOG2)
			size_reg = val;
		else
			grid_reg = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic feed_to_done();
		while (map_phase == PH_FEED)
			send_beat(MODE_FEED, 15'($urandom));
	endtask

	task automatic build_map(logic [3:0] sz, logic [3:0] gr, int reads);
		write_reg(CFG_SIZE_LOG2, sz);
		write_reg(CFG_GRID_LOG2, gr);
		send_beat(MODE_START, 15'($urandom));
		feed_to_done();
		repeat (reads) send_beat(MODE_READ, 15'($urandom));
	endtask

	task automatic test_before_start();
		send_beat(MODE_READ, 15'h7FFF);
		send_beat(MODE_FEED, 15'h0000);
		send_beat(MODE_UNUSED, 15'h5555);
	endtask

	task automatic test_smallest_map();
		// One level of spacing one on a 2x2 map; words at both extremes, then a
		// readout that wraps around to the first cell.
		write_reg(CFG_SIZE_LOG2, 4'd0);
		write_reg(CFG_GRID_LOG2, 4'd0);
		send_beat(MODE_START, 15'd0);
		send_beat(MODE_READ, 15'd0);
		send_beat(MODE_FEED, 15'h7FFF);
		send_beat(MODE_FEED, 15'h0000);
		send_beat(MODE_FEED, 15'h2AAA);
		send_beat(MODE_FEED, 15'h7FFF);
		repeat (6) send_beat(MODE_READ, 15'h7FFF);
		send_beat(MODE_FEED, 15'h1234);
		send_beat(MODE_UNUSED, 15'h7FFF);
	endtask

	task automatic test_grid_clamp_and_restart();
		build_map(4'd2, 4'd15, 17);
		// A start in the middle of a map throws the partial map away.
		send_beat(MODE_START, 15'd0);
		repeat (3) send_beat(MODE_FEED, 15'h7FFF);
		write_reg(CFG_SIZE_LOG2, 4'd1);
		send_beat(MODE_FEED, 15'h4321);
		send_beat(MODE_START, 15'd0);
		feed_to_done();
		repeat (4) send_beat(MODE_READ, 15'd0);
	endtask

	task automatic test_widest_map();
		// Side registers above the maximum saturate; only a few words are fed
		// since a full map at this size would take far too long.
		write_reg(CFG_SIZE_LOG2, 4'd15);
		write_reg(CFG_GRID_LOG2, 4'd8);
		send_beat(MODE_START, 15'd0);
		repeat (2) send_beat(MODE_FEED, 15'($urandom));
		write_reg(CFG_SIZE_LOG2, 4'd9);
		write_reg(CFG_GRID_LOG2, 4'd4);
		send_beat(MODE_START, 15'd0);
		send_beat(MODE_READ, 15'd1);
	endtask

	task automatic test_backpressure();
		write_reg(CFG_SIZE_LOG2, 4'd2);
		write_reg(CFG_GRID_LOG2, 4'd1);
		send_beat(MODE_START, 15'd0);
		hold_cycles = 300;
		feed_to_done();
		repeat (20) send_beat(MODE_READ, 15'd0);
		drain();
	endtask

	task automatic test_random_maps(int budget);
		int first, n, r;
		first = beats_sent;
		while (beats_sent - first < budget) begin
			if (gaps_on == 1'b0 || $urandom_range(0, 4) != 0) begin
				n = $urandom_range(1, 3);
				if (n == 3 && $urandom_range(0, 2) != 0)
					n = 2;
				build_map(4'(n), 4'($urandom_range(0, n + 1)), 0);
				r = (1 << (2 * n)) + $urandom_range(0, 3);
				repeat (r) begin
					if ($urandom_range(0, 12) == 0)
						send_beat(2'($urandom_range(1, 3)), 15'($urandom));
					else
						send_beat(MODE_READ, 15'($urandom));
				end
			end else begin
				// Broken sequences: stray words, unused modes, early starts.
				send_beat(MODE_START, 15'($urandom));
				repeat ($urandom_range(1, 6))
					send_beat(2'($urandom_range(0, 3)), 15'($urandom));
			end
		end
	endtask

	// Result side: random stalls, one long hold-off when asked.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready = 1'b0;
				hold_cycles--;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		noise_res_t e;
		if (m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected result noise=%0d done=%0b last=%0b err=%0b",
					$time, m_tdata, m_tuser[USER_DONE], m_tlast, m_tuser[USER_ERROR]);
				fails++;
			end else begin
				e = expected_bytes.pop_front();
				bytes_checked++;
				if (m_tdata !== e.noise || m_tuser[USER_DONE] !== e.done ||
						m_tlast !== e.last || m_tuser[USER_ERROR] !== e.err) begin
					$display("%0t: mismatch expected noise=%0d done=%0b last=%0b err=%0b",
						$time, e.noise, e.done, e.last, e.err);
					$display("%0t:          actual   noise=%0d done=%0b last=%0b err=%0b",
						$time, m_tdata, m_tuser[USER_DONE], m_tlast, m_tuser[USER_ERROR]);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		fails = 0;
		cycles = 0;
		beats_sent = 0;
		bytes_checked = 0;
		maps_done = 0;
		hold_cycles = 0;
		gaps_on = 1'b1;
		size_reg = SIZE_LOG2_RESET;
		grid_reg = GRID_LOG2_RESET;
		map_phase = PH_IDLE;
		spacing = 0;
		feed_pos = 0;
		peak = 0;
		read_pos = 0;
		side_l2 = 0;
		level_l2 = 0;
		amp = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_before_start();
		test_smallest_map();
		test_grid_clamp_and_restart();
		test_widest_map();
		test_backpressure();
		test_random_maps(220);
		gaps_on = 1'b0;
		test_random_maps(60);

		drain();
		$display("Covered %0d input beats and %0d results over %0d finished maps,",
			beats_sent, bytes_checked, maps_done);
		$display("with side and grid extremes, stray items, restarts and long stalls.");
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
